### src/mean_intensity_projection_core_macros.svh
// Assertion macros for the projection core. Each use sits on a line of its own.
`ifndef MEAN_INTENSITY_PROJECTION_CORE_MACROS_SVH
`define MEAN_INTENSITY_PROJECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MIP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define MIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MIP_ASSERT_SAME(label, ante, cons, msg)
`define MIP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/mip_pkg.sv
package mip_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 128;

   localparam int unsigned VOXEL_W    = 16;
   localparam int unsigned PIX_W      = 14;
   localparam int unsigned MEAN_W     = 24;
   localparam int unsigned SUM_W      = 24;
   localparam int unsigned SIZE_W     = 8;
   localparam int unsigned FRAC_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // restoring divider: sum scaled by 2^FRAC_W, a fixed number of steps per stage
   localparam int unsigned DIVIDEND_W      = SUM_W + FRAC_W;
   localparam int unsigned STEPS_PER_STAGE = 8;
   localparam int unsigned DIV_STAGES      = DIVIDEND_W / STEPS_PER_STAGE;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2,
      REG_AXIS   = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic [PIX_W-1:0]      pixel_index;
      logic                  volume_done;
      logic                  neg;
      logic [SIZE_W-1:0]     divisor;
      logic [SIZE_W-1:0]     rem;
      logic [DIVIDEND_W-1:0] quo;
   } div_type;

   // one restoring step: shift the next dividend bit into the remainder
   function automatic div_type div_step(div_type d);
      div_type           r;
      logic [SIZE_W:0]   trial;
      r     = d;
      trial = {d.rem, d.quo[DIVIDEND_W-1]};
      if (trial >= {1'b0, d.divisor}) begin
         r.rem = SIZE_W'(trial - {1'b0, d.divisor});
         r.quo = {d.quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
         r.rem = trial[SIZE_W-1:0];
         r.quo = {d.quo[DIVIDEND_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

### src/mip_ifs.sv
interface mip_req_if import mip_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VOXEL_W-1:0] voxel;

   modport source (output valid, output voxel, input ready);
   modport sink   (input valid, input voxel, output ready);
endinterface

interface mip_rsp_if import mip_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [PIX_W-1:0]         pixel_index;
   logic signed [MEAN_W-1:0] mean_q8;
   logic                     volume_done;

   modport source (output valid, output pixel_index, output mean_q8, output volume_done,
                   input ready);
   modport sink   (input valid, input pixel_index, input mean_q8, input volume_done,
                   output ready);
endinterface

interface mip_csr_if import mip_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/mean_intensity_projection_core.sv
// Throughput: one voxel beat per cycle, less when rsp back-pressure stalls a final voxel;
//   the sum store does a read-modify-write per voxel, forwarding the last written entry
//   so back-to-back hits on one pixel chain up. Path: sum store read, add/write, stage 2,
//   four 8-step divider stages, then the output register that drives rsp.
// Reset: synchronous, active high; sizes return to 1, axis to z, position to the origin.
//   The sum store is not cleared: each pixel's first voxel overwrites its entry.
`include "mean_intensity_projection_core_macros.svh"

module mean_intensity_projection_core import mip_pkg::*; #(
   parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mip_req_if.sink    req_chan,
   mip_rsp_if.source  rsp_chan,
   mip_csr_if.sink    csr_chan
);

   // Size registers are 8 bits wide: the usable extent caps at MAX_DIM, and never above 255.
   localparam int unsigned SIZE_CAP_I = (MAX_DIM > 255) ? 255 : MAX_DIM;
   localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(SIZE_CAP_I);
   localparam int unsigned POS_W      = $clog2(SIZE_CAP_I);
   localparam int unsigned MEM_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);
   localparam int unsigned PROD_W     = SIZE_W + POS_W + 1;
   localparam int unsigned LAST_STAGE = DIV_STAGES - 1;

   // ------------------------------------------------------------------
   // Configuration registers. Hold clamped sizes so the datapath never
   // sees zero or an extent above the cap.
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0] size_x_ff;
   logic [SIZE_W-1:0] size_y_ff;
   logic [SIZE_W-1:0] size_z_ff;
   axis_type          axis_ff;
   logic              csr_fire;

   function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_CAP) begin
         r = SIZE_CAP;
      end
      return r;
   endfunction

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_W'(1);
         size_y_ff <= SIZE_W'(1);
         size_z_ff <= SIZE_W'(1);
         axis_ff   <= AXIS_Z;
      end else if (csr_fire) begin
         unique case (csr_reg_type'(csr_chan.index))
            REG_SIZE_X: begin
               size_x_ff <= clamp_size(csr_chan.data);
            end
            REG_SIZE_Y: begin
               size_y_ff <= clamp_size(csr_chan.data);
            end
            REG_SIZE_Z: begin
               size_z_ff <= clamp_size(csr_chan.data);
            end
            REG_AXIS: begin
               // the unused axis code folds onto z
               axis_ff <= (csr_chan.data[1:0] > AXIS_Z) ? AXIS_Z : axis_type'(csr_chan.data[1:0]);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Voxel position and address generation (accept stage).
   // ------------------------------------------------------------------
   logic [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic [POS_W-1:0]  pos_x_in, pos_y_in, pos_z_in;
   logic              x_last, y_last, z_last;
   logic              along_first, along_last;
   logic [SIZE_W-1:0] extent;
   logic [PROD_W-1:0] pix_in;
   logic              req_fire;
   logic              s1_ready;

   assign req_chan.ready = s1_ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign x_last = SIZE_W'(pos_x_ff) == (size_x_ff - SIZE_W'(1));
   assign y_last = SIZE_W'(pos_y_ff) == (size_y_ff - SIZE_W'(1));
   assign z_last = SIZE_W'(pos_z_ff) == (size_z_ff - SIZE_W'(1));

   // Drop the coordinate along the axis; the first remaining axis runs fastest.
   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            along_first = pos_x_ff == '0;
            along_last  = x_last;
            extent      = size_x_ff;
            pix_in      = PROD_W'(pos_y_ff) + PROD_W'(size_y_ff) * PROD_W'(pos_z_ff);
         end
         AXIS_Y: begin
            along_first = pos_y_ff == '0;
            along_last  = y_last;
            extent      = size_y_ff;
            pix_in      = PROD_W'(pos_x_ff) + PROD_W'(size_x_ff) * PROD_W'(pos_z_ff);
         end
         AXIS_Z: begin
            along_first = pos_z_ff == '0;
            along_last  = z_last;
            extent      = size_z_ff;
            pix_in      = PROD_W'(pos_x_ff) + PROD_W'(size_x_ff) * PROD_W'(pos_y_ff);
         end
         default: begin
            along_first = pos_z_ff == '0;
            along_last  = z_last;
            extent      = size_z_ff;
            pix_in      = PROD_W'(pos_x_ff) + PROD_W'(size_x_ff) * PROD_W'(pos_y_ff);
         end
      endcase
   end

   // Advance x fastest; any register write restarts the volume at the origin.
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (csr_fire) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (req_fire) begin
         if (!x_last) begin
            pos_x_in = pos_x_ff + POS_W'(1);
         end else begin
            pos_x_in = '0;
            if (!y_last) begin
               pos_y_in = pos_y_ff + POS_W'(1);
            end else begin
               pos_y_in = '0;
               pos_z_in = z_last ? '0 : pos_z_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: sum store read is in flight; add and write back here.
   // ------------------------------------------------------------------
   logic                      s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]         s1_addr_ff;
   logic [PIX_W-1:0]          s1_pix_ff;
   logic signed [VOXEL_W-1:0] s1_voxel_ff;
   logic                      s1_first_ff, s1_last_ff, s1_done_ff;
   logic [SIZE_W-1:0]         s1_extent_ff;
   logic                      s1_go, s1_fire;

   logic signed [SUM_W-1:0]   sum_mem [MEM_DEPTH];
   logic signed [SUM_W-1:0]   rd_data_ff;
   logic                      wr_valid_ff;
   logic [ADDR_W-1:0]         wr_addr_ff;
   logic signed [SUM_W-1:0]   wr_data_ff;
   logic                      fwd_hit;
   logic signed [SUM_W-1:0]   sum_base;
   logic signed [SUM_W-1:0]   sum_in;
   logic                      s2_ready;

   // Non-final voxels retire without a result, so they never wait on the divider.
   assign s1_go       = !s1_last_ff || s2_ready;
   assign s1_fire     = s1_valid_ff && s1_go;
   assign s1_ready    = !s1_valid_ff || s1_go;
   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // The store read sees every write except one landing on the same edge; forward
   // the latest write so consecutive voxels of one pixel accumulate correctly.
   assign fwd_hit  = wr_valid_ff && (wr_addr_ff == s1_addr_ff);
   assign sum_base = s1_first_ff ? '0 : (fwd_hit ? wr_data_ff : rd_data_ff);
   assign sum_in   = sum_base + SUM_W'(s1_voxel_ff);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= sum_mem[ADDR_W'(pix_in)];
      end
      if (s1_fire) begin
         sum_mem[s1_addr_ff] <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_fire) begin
            wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_ff   <= ADDR_W'(pix_in);
         s1_pix_ff    <= PIX_W'(pix_in);
         s1_voxel_ff  <= req_chan.voxel;
         s1_first_ff  <= along_first;
         s1_last_ff   <= along_last;
         s1_done_ff   <= x_last && y_last && z_last;
         s1_extent_ff <= extent;
      end
      if (s1_fire) begin
         wr_addr_ff <= s1_addr_ff;
         wr_data_ff <= sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: finished pixel sum waiting to enter the divider.
   // ------------------------------------------------------------------
   logic                    s2_valid_ff, s2_valid_in;
   logic [PIX_W-1:0]        s2_pix_ff;
   logic                    s2_done_ff;
   logic signed [SUM_W-1:0] s2_sum_ff;
   logic [SIZE_W-1:0]       s2_extent_ff;
   logic                    s2_neg;
   logic [SUM_W-1:0]        s2_mag;
   logic                    s2_load;
   logic [DIV_STAGES-1:0]   div_ready;

   assign s2_ready    = !s2_valid_ff || div_ready[0];
   assign s2_load     = s2_ready && s1_fire && s1_last_ff;
   assign s2_valid_in = s2_ready ? (s1_fire && s1_last_ff) : s2_valid_ff;
   assign s2_neg      = s2_sum_ff[SUM_W-1];
   assign s2_mag      = s2_neg ? SUM_W'(-s2_sum_ff) : SUM_W'(s2_sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_pix_ff    <= s1_pix_ff;
         s2_done_ff   <= s1_done_ff;
         s2_sum_ff    <= sum_in;
         s2_extent_ff <= s1_extent_ff;
      end
   end

   // ------------------------------------------------------------------
   // Divider: magnitude times 2^FRAC_W over the extent, restoring,
   // STEPS_PER_STAGE quotient bits per stage. Sign goes back on at the end,
   // which truncates toward zero.
   // ------------------------------------------------------------------
   div_type               div_ff      [DIV_STAGES];
   div_type               div_src     [DIV_STAGES];
   div_type               div_next    [DIV_STAGES];
   logic [DIV_STAGES-1:0] div_valid_ff, div_valid_in;
   logic [DIV_STAGES-1:0] div_src_valid;
   logic [DIV_STAGES-1:0] div_load;
   logic                  out_ready;

   always_comb begin
      div_ready[LAST_STAGE] = !div_valid_ff[LAST_STAGE] || out_ready;
      for (int k = int'(LAST_STAGE) - 1; k >= 0; k--) begin
         div_ready[k] = !div_valid_ff[k] || div_ready[k+1];
      end
   end

   always_comb begin
      div_src[0].pixel_index = s2_pix_ff;
      div_src[0].volume_done = s2_done_ff;
      div_src[0].neg         = s2_neg;
      div_src[0].divisor     = s2_extent_ff;
      div_src[0].rem         = '0;
      div_src[0].quo         = {s2_mag, {FRAC_W{1'b0}}};
      div_src_valid[0]       = s2_valid_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         div_src[k]       = div_ff[k-1];
         div_src_valid[k] = div_valid_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_next[k] = div_src[k];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            div_next[k] = div_step(div_next[k]);
         end
         div_load[k]     = div_ready[k] && div_src_valid[k];
         div_valid_in[k] = div_ready[k] ? div_src_valid[k] : div_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
      end else begin
         div_valid_ff <= div_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (div_load[k]) begin
            div_ff[k] <= div_next[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register: parts the divider from the result channel.
   // ------------------------------------------------------------------
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]         rsp_pix_ff;
   logic signed [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic                     rsp_done_ff;
   logic                     rsp_load;

   assign out_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load     = out_ready && div_valid_ff[LAST_STAGE];
   assign rsp_valid_in = out_ready ? div_valid_ff[LAST_STAGE] : rsp_valid_ff;
   assign rsp_mean_in  = div_ff[LAST_STAGE].neg ?
                         MEAN_W'(-div_ff[LAST_STAGE].quo[MEAN_W-1:0]) :
                         MEAN_W'(div_ff[LAST_STAGE].quo[MEAN_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pix_ff  <= div_ff[LAST_STAGE].pixel_index;
         rsp_mean_ff <= rsp_mean_in;
         rsp_done_ff <= div_ff[LAST_STAGE].volume_done;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_index = rsp_pix_ff;
   assign rsp_chan.mean_q8     = rsp_mean_ff;
   assign rsp_chan.volume_done = rsp_done_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `MIP_ASSERT_SAME(a_pos_in_volume, 1'b1, (SIZE_W'(pos_x_ff) < size_x_ff) && (SIZE_W'(pos_y_ff) < size_y_ff) && (SIZE_W'(pos_z_ff) < size_z_ff), "position outside the volume")
   `MIP_ASSERT_NEXT(a_result_kept, s1_fire && s1_last_ff, s2_valid_ff, "finished pixel sum lost")
   `MIP_ASSERT_SAME(a_div_rem_bound, div_valid_ff[LAST_STAGE], div_ff[LAST_STAGE].rem < div_ff[LAST_STAGE].divisor, "divider remainder not below divisor")
   `MIP_ASSERT_SAME(a_mean_fits, div_valid_ff[LAST_STAGE], div_ff[LAST_STAGE].quo[DIVIDEND_W-1:MEAN_W] == '0, "mean overflows output width")

endmodule

### tb/mean_intensity_projection_core_tb.sv
`timescale 1ns / 1ps

module mean_intensity_projection_core_tb;
   import mip_pkg::*;

   localparam int unsigned DIM           = MAX_DIM_DEFAULT;
   localparam int unsigned RESET_CYCLES  = 7;
   // let the pipeline empty before a register write or the verdict
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned LONG_HOLD     = 200;
   localparam int unsigned RANDOM_VOXELS = 350;
   localparam time         TIMEOUT_NS    = 5_000_000;

   // axis code 3 is not in the package enum; the block folds it onto z
   localparam logic [1:0] AXIS_Z_ALIAS = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0]         pixel_index;
      logic signed [MEAN_W-1:0] mean_q8;
      logic                     volume_done;
   } pixel_mean_type;

   typedef enum bit {ROW_VOXEL, ROW_WRITE} row_kind_type;

   // one line of the directed plan; when 'typed' is set the mean beat is spelled out here
   typedef struct packed {
      row_kind_type              kind;
      csr_reg_type               reg_idx;
      logic [CSR_DATA_W-1:0]     reg_data;
      logic signed [VOXEL_W-1:0] voxel;
      bit                        typed;
      logic [PIX_W-1:0]          pix;
      logic signed [MEAN_W-1:0]  mean;
      bit                        done;
   } plan_row_type;

   localparam int unsigned PLAN_ROWS = 38;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // after reset: 1x1x1 volume along z, so every voxel is its own pixel mean
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd32767, 1'b1, 14'd0, 24'sd8388352, 1'b1},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sh8000,  1'b1, 14'd0, 24'sh800000,  1'b1},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd0,     1'b1, 14'd0, 24'sd0,       1'b1},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd1,     1'b1, 14'd0, 24'sd256,     1'b1},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, -16'sd1,    1'b1, 14'd0, 24'shFFFF00,  1'b1},
      // a size of zero behaves as one
      '{ROW_WRITE, REG_SIZE_X, 8'd0, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd100,   1'b1, 14'd0, 24'sd25600,   1'b1},
      // axis code 3 folds onto z; three deep along z
      '{ROW_WRITE, REG_AXIS,   8'(AXIS_Z_ALIAS), 16'sd0, 1'b0, 14'd0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_SIZE_Z, 8'd3, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      // -1/3 must truncate toward zero
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, -16'sd1,    1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      // full-scale sum over three voxels
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd32767, 1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd32767, 1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd32767, 1'b1, 14'd0, 24'sd8388352, 1'b1},
      // part of a volume, then a write must rewind to the origin
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd7,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_WRITE, REG_AXIS,   8'(AXIS_Z), 16'sd0, 1'b0, 14'd0, 24'sd0,     1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd3,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd3,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd4,     1'b0, 14'd0, 24'sd0,       1'b0},
      // 2x2x1 projected along x
      '{ROW_WRITE, REG_SIZE_Z, 8'd1, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_WRITE, REG_SIZE_X, 8'd2, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_WRITE, REG_SIZE_Y, 8'd2, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_WRITE, REG_AXIS,   8'(AXIS_X), 16'sd0, 1'b0, 14'd0, 24'sd0,     1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, -16'sd5,    1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd6,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd7,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, -16'sd8,    1'b0, 14'd0, 24'sd0,       1'b0},
      // same volume projected along y
      '{ROW_WRITE, REG_AXIS,   8'(AXIS_Y), 16'sd0, 1'b0, 14'd0, 24'sd0,     1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd1,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd2,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd3,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd4,     1'b0, 14'd0, 24'sd0,       1'b0},
      // oversize x clamps; the row of pixels runs on without volume_done
      '{ROW_WRITE, REG_SIZE_X, 8'd255, 16'sd0,   1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_WRITE, REG_SIZE_Y, 8'd1, 16'sd0,     1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_WRITE, REG_AXIS,   8'(AXIS_Z), 16'sd0, 1'b0, 14'd0, 24'sd0,     1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, 16'sd11,    1'b0, 14'd0, 24'sd0,       1'b0},
      '{ROW_VOXEL, REG_SIZE_X, 8'd0, -16'sd12,   1'b0, 14'd0, 24'sd0,       1'b0}
   };

   logic clock;
   logic reset;

   mip_req_if req_bus ();
   mip_rsp_if rsp_bus ();
   mip_csr_if csr_bus ();

   mean_intensity_projection_core #(
      .MAX_DIM (DIM)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // mirror of the block's registers, scan position and sum store
   logic [SIZE_W-1:0] size_shadow [3];
   logic [1:0]        axis_shadow;
   int unsigned       at_x;
   int unsigned       at_y;
   int unsigned       at_z;
   int                sum_store [DIM*DIM];

   // pixel means still owed by the block, oldest first
   pixel_mean_type pending_means [$];
   int             error_count;

   // knobs shared by the sender and receiver processes
   bit no_idle;
   bit hold_off_req;

   always #6 clock = ~clock;

   function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > DIM) return DIM;
      return raw;
   endfunction

   // Any register write rewinds the scan to the origin.
   function automatic void apply_reg_write(input csr_reg_type idx,
                                           input logic [CSR_DATA_W-1:0] d);
      if (idx == REG_AXIS) axis_shadow = d[1:0];
      else size_shadow[idx] = d;
      at_x = 0;
      at_y = 0;
      at_z = 0;
   endfunction

   // Fold one voxel into its pixel's sum; return 1 with the mean when the pixel completes.
   function automatic bit accumulate_voxel(input logic signed [VOXEL_W-1:0] v,
                                           output pixel_mean_type res);
      int unsigned sx;
      int unsigned sy;
      int unsigned sz;
      int unsigned along;
      int unsigned extent;
      int unsigned pix;
      int          sum;
      longint      scaled;
      bit          last_voxel;
      bit          completes;
      sx  = clamp_size(size_shadow[REG_SIZE_X]);
      sy  = clamp_size(size_shadow[REG_SIZE_Y]);
      sz  = clamp_size(size_shadow[REG_SIZE_Z]);
      res = '0;
      if (at_x >= sx || at_y >= sy || at_z >= sz) begin
         at_x = 0;
         at_y = 0;
         at_z = 0;
      end
      if (axis_shadow == AXIS_X) begin
         along  = at_x;
         extent = sx;
         pix    = at_y + sy * at_z;
      end else if (axis_shadow == AXIS_Y) begin
         along  = at_y;
         extent = sy;
         pix    = at_x + sx * at_z;
      end else begin
         along  = at_z;
         extent = sz;
         pix    = at_x + sx * at_y;
      end
      pix = pix % (DIM * DIM);
      // first contribution overwrites, so stale entries are never read
      sum = (along == 0) ? int'(v) : sum_store[pix] + int'(v);
      sum_store[pix] = sum;
      last_voxel = (at_x == sx - 1) && (at_y == sy - 1) && (at_z == sz - 1);
      completes  = (along == extent - 1);
      if (completes) begin
         scaled          = (longint'(sum) * 256) / longint'(extent);
         res.pixel_index = pix[PIX_W-1:0];
         res.mean_q8     = scaled[MEAN_W-1:0];
         res.volume_done = last_voxel;
      end
      // advance x fastest, then y, then z, wrapping at the volume end
      at_x++;
      if (at_x >= sx) begin
         at_x = 0;
         at_y++;
         if (at_y >= sy) begin
            at_y = 0;
            at_z++;
            if (at_z >= sz) at_z = 0;
         end
      end
      return completes;
   endfunction

   // Offer one voxel beat after a random gap and hold it until taken. The expectation is
   // booked before the beat is offered, well ahead of any mean beat it can cause.
   task automatic send_voxel(input logic signed [VOXEL_W-1:0] v, input bit typed = 1'b0,
                             input pixel_mean_type typed_res = '0);
      int unsigned    gap;
      pixel_mean_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (accumulate_voxel(v, predicted)) pending_means.push_back(typed ? typed_res : predicted);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.voxel <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop the voxel stream, let every owed mean drain, then give the pipe time to empty.
   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      do @(posedge clock); while (!csr_bus.ready);
      apply_reg_write(idx, d);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [VOXEL_W-1:0] draw_voxel(input int unsigned flavor);
      case (flavor)
         0: return 16'sd32767;
         1: return 16'sh8000;
         2: return VOXEL_W'($signed($urandom_range(0, 8)) - 4);
         default: return VOXEL_W'($urandom());
      endcase
   endfunction

   // Receiver: draw a stall per mean beat; on request hold off for a long stretch so the
   // pipe backs up into the voxel input.
   initial begin
      int unsigned stall;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_req) begin
            stall        = LONG_HOLD;
            hold_off_req = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Checker: compare each mean beat taken with the oldest owed one.
   always @(posedge clock) begin
      pixel_mean_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected mean beat: pixel %0d mean %0d done %0b", $time,
                     rsp_bus.pixel_index, $signed(rsp_bus.mean_q8), rsp_bus.volume_done);
            error_count++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_bus.pixel_index !== want.pixel_index) begin
               $display("%0t: pixel_index expected %0d actual %0d", $time,
                        want.pixel_index, rsp_bus.pixel_index);
               error_count++;
            end
            if (rsp_bus.mean_q8 !== want.mean_q8) begin
               $display("%0t: mean_q8 expected %0d actual %0d (pixel %0d)", $time,
                        $signed(want.mean_q8), $signed(rsp_bus.mean_q8), want.pixel_index);
               error_count++;
            end
            if (rsp_bus.volume_done !== want.volume_done) begin
               $display("%0t: volume_done expected %0b actual %0b (pixel %0d)", $time,
                        want.volume_done, rsp_bus.volume_done, want.pixel_index);
               error_count++;
            end
         end
      end
   end

   // Watchdog: give up well beyond the slowest legal run.
   initial begin
      #(TIMEOUT_NS);
      $display("mean_intensity_projection_core_tb: errors");
      $finish;
   end

   initial begin
      logic [SIZE_W-1:0] raw [3];
      logic [1:0]        ax;
      int unsigned       big;
      int unsigned       vol;
      int unsigned       count;
      int unsigned       flavor;
      int unsigned       phase;
      int unsigned       voxels_sent;
      plan_row_type      row;

      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.voxel = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_SIZE_X;
      csr_bus.data  = '0;
      error_count   = 0;
      no_idle       = 1'b0;
      hold_off_req  = 1'b0;
      // reset values: 1x1x1 volume, projected along z
      size_shadow[REG_SIZE_X] = 8'd1;
      size_shadow[REG_SIZE_Y] = 8'd1;
      size_shadow[REG_SIZE_Z] = 8'd1;
      axis_shadow             = AXIS_Z;
      at_x = 0;
      at_y = 0;
      at_z = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed plan; settle the block before every register write.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = DIRECTED_PLAN[i];
         if (row.kind == ROW_WRITE) begin
            settle_block();
            write_reg(row.reg_idx, row.reg_data);
         end else begin
            send_voxel(row.voxel, row.typed, '{row.pix, row.mean, row.done});
         end
      end

      // Back pressure: a mean per voxel, no sender gaps, and a long receiver hold so the
      // pipe fills and stalls the voxel input.
      settle_block();
      write_reg(REG_SIZE_X, 8'd16);
      write_reg(REG_SIZE_Y, 8'd8);
      write_reg(REG_SIZE_Z, 8'd1);
      write_reg(REG_AXIS, 8'(AXIS_Z));
      no_idle      = 1'b1;
      hold_off_req = 1'b1;
      repeat (128) send_voxel(draw_voxel(3));
      no_idle = 1'b0;

      // Random phases: pick a shape, stream whole volumes (sometimes a cut-off one, which
      // the next write abandons). Every fourth phase stretches one axis to its limit.
      phase       = 0;
      voxels_sent = 0;
      while (voxels_sent < RANDOM_VOXELS) begin
         if (phase % 4 == 1) begin
            big = $urandom_range(0, 2);
            for (int d = 0; d < 3; d++) raw[d] = SIZE_W'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
               0: raw[big] = 8'd128;
               1: raw[big] = 8'd129;
               2: raw[big] = 8'd200;
               default: raw[big] = 8'd255;
            endcase
         end else begin
            for (int d = 0; d < 3; d++) raw[d] = SIZE_W'($urandom_range(0, 5));
         end
         ax = 2'($urandom_range(0, 3));

         settle_block();
         write_reg(REG_SIZE_X, raw[0]);
         write_reg(REG_SIZE_Y, raw[1]);
         write_reg(REG_SIZE_Z, raw[2]);
         write_reg(REG_AXIS, 8'(ax));

         vol   = clamp_size(raw[0]) * clamp_size(raw[1]) * clamp_size(raw[2]);
         count = vol * $urandom_range(1, 3);
         if (count > 150) count = vol;
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, vol);
         // mostly full-range noise, now and then rails or tiny values
         flavor  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (count) send_voxel(draw_voxel(flavor));
         voxels_sent += count;
         phase++;
      end
      no_idle = 1'b0;

      settle_block();
      if (error_count == 0) begin
         $display("mean_intensity_projection_core_tb: clean");
      end else begin
         $display("mean_intensity_projection_core_tb: errors");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/mip_pkg.sv
src/mip_ifs.sv
src/mean_intensity_projection_core.sv
tb/mean_intensity_projection_core_tb.sv
